// ===== design/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared types and constants of the divisible subarray counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsc_pkg;

  // sizing
  localparam int MOD_MAX   = 1024;
  localparam int MAX_ITEMS = 1048576;

  // fixed field widths
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 40;
  localparam int PREFIX_W   = 10;
  localparam int MODULUS_W  = 11;

  // derived widths
  localparam int REM_W      = $clog2(MOD_MAX);
  localparam int MEFF_W     = REM_W + 1;
  localparam int HIST_W     = $clog2(MAX_ITEMS) + 1;

  // remainder unit: a few dividend bits per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = (VALUE_W + 1 + DIV_BITS - 1) / DIV_BITS;
  localparam int DIVQ_W     = DIV_STEPS * DIV_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // configuration port
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam logic REG_MODULUS = 1'b0;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first_item;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  subarray_count;
    logic [PREFIX_W-1:0] prefix_remainder;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

// ===== design/dsc_ram.sv =====
// ----------------------------------------------------------------------------
// dsc_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/divisible_subarray_counter.sv =====
// Sequence: an accepted request runs the remainder steps, one histogram read and
//   one update; a first_item request adds a full histogram sweep before them.
// Pace: a new request waits until the last result is loaded, set by the 4-bit-per-cycle
//   remainder unit, the read-modify-write of the single-port histogram RAM and out_stall.
// Reset: synchronous active-low; after reset a sweep seeds the
//   histogram (entry zero one, others zero) with in_stall high; config is taken.
// ----------------------------------------------------------------------------
// divisible_subarray_counter
// Counts subarrays with sum divisible by a modulus using a remainder histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module divisible_subarray_counter (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  dsc_pkg::in_item_t            in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output dsc_pkg::out_item_t           out_data,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsc_pkg::PADDR_W-1:0]  paddr,
  input  logic [dsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [dsc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  dsc_pkg::state_t                     state_r;
  logic [dsc_pkg::MODULUS_W-1:0]       modulus_r;
  logic [dsc_pkg::MEFF_W-1:0]          m_eff;
  logic [dsc_pkg::REM_W-1:0]           rem_run_r;
  logic [dsc_pkg::COUNT_W-1:0]         total_r;
  logic [dsc_pkg::DIVQ_W-1:0]          dividend_r;
  logic [dsc_pkg::MEFF_W-1:0]          rem_r;
  logic [dsc_pkg::MEFF_W-1:0]          rem_nxt;
  logic [dsc_pkg::STEP_W-1:0]          step_r;
  logic [dsc_pkg::REM_W-1:0]           clr_idx_r;
  logic                                pending_r;
  logic                                out_valid_r;
  dsc_pkg::out_item_t                  out_data_r;
  logic                                in_accept;
  logic                                slot_free;
  logic                                cfg_wr;
  logic                                ram_we;
  logic [dsc_pkg::REM_W-1:0]           ram_addr;
  logic [dsc_pkg::HIST_W-1:0]          ram_wdata;
  logic [dsc_pkg::HIST_W-1:0]          ram_rdata;
  logic [dsc_pkg::COUNT_W:0]           sum_wide;
  logic [dsc_pkg::COUNT_W-1:0]         total_nxt;
  logic [dsc_pkg::REM_W-1:0]           rem_final;

  // handshake
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != dsc_pkg::S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == dsc_pkg::REG_MODULUS) ?
                  dsc_pkg::PDATA_W'(modulus_r) : '0;

  // effective modulus, clamped to 1..MOD_MAX
  always_comb begin
    if (modulus_r == '0) begin
      m_eff = dsc_pkg::MEFF_W'(1);
    end else if (int'(modulus_r) > dsc_pkg::MOD_MAX) begin
      m_eff = dsc_pkg::MEFF_W'(dsc_pkg::MOD_MAX);
    end else begin
      m_eff = dsc_pkg::MEFF_W'(int'(modulus_r));
    end
  end

  // restoring remainder step over the top dividend bits
  always_comb begin
    logic [dsc_pkg::MEFF_W-1:0] acc;
    acc = rem_r;
    for (int i = 0; i < dsc_pkg::DIV_BITS; i++) begin
      acc = {acc[dsc_pkg::MEFF_W-2:0], dividend_r[dsc_pkg::DIVQ_W-1-i]};
      if (acc >= m_eff) begin
        acc = acc - m_eff;
      end
    end
    rem_nxt = acc;
  end

  assign rem_final = rem_r[dsc_pkg::REM_W-1:0];

  // saturating total and histogram update
  assign sum_wide  = {1'b0, total_r} + (dsc_pkg::COUNT_W + 1)'(ram_rdata);
  assign total_nxt = sum_wide[dsc_pkg::COUNT_W] ? '1 : sum_wide[dsc_pkg::COUNT_W-1:0];

  // histogram ram port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rem_final;
    ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + dsc_pkg::HIST_W'(1);
    case (state_r)
      dsc_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_idx_r;
        ram_wdata = (clr_idx_r == '0) ? dsc_pkg::HIST_W'(1) : '0;
      end
      dsc_pkg::S_DONE: begin
        ram_we = slot_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dsc_ram #(
    .WIDTH (dsc_pkg::HIST_W),
    .DEPTH (dsc_pkg::MOD_MAX)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsc_pkg::S_CLEAR;
      clr_idx_r   <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      modulus_r   <= dsc_pkg::MODULUS_W'(1);
      rem_run_r   <= '0;
      total_r     <= '0;
      step_r      <= '0;
    end else begin
      if (cfg_wr && paddr[2] == dsc_pkg::REG_MODULUS) begin
        modulus_r <= pwdata[dsc_pkg::MODULUS_W-1:0];
      end
      // the update state reloads the result slot itself
      if (out_valid_r && !out_stall && state_r != dsc_pkg::S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        dsc_pkg::S_CLEAR: begin
          clr_idx_r <= clr_idx_r + dsc_pkg::REM_W'(1);
          if (clr_idx_r == '1) begin
            state_r <= pending_r ? dsc_pkg::S_DIV : dsc_pkg::S_IDLE;
          end
        end
        dsc_pkg::S_IDLE: begin
          if (in_accept) begin
            rem_r  <= '0;
            step_r <= dsc_pkg::STEP_W'(dsc_pkg::DIV_STEPS - 1);
            if (in_data.first_item) begin
              dividend_r <= dsc_pkg::DIVQ_W'(in_data.value);
              rem_run_r  <= '0;
              total_r    <= '0;
              clr_idx_r  <= '0;
              pending_r  <= 1'b1;
              state_r    <= dsc_pkg::S_CLEAR;
            end else begin
              dividend_r <= dsc_pkg::DIVQ_W'(in_data.value) + dsc_pkg::DIVQ_W'(rem_run_r);
              state_r    <= dsc_pkg::S_DIV;
            end
          end
        end
        dsc_pkg::S_DIV: begin
          rem_r      <= rem_nxt;
          dividend_r <= dividend_r << dsc_pkg::DIV_BITS;
          step_r     <= step_r - dsc_pkg::STEP_W'(1);
          if (step_r == '0) begin
            state_r <= dsc_pkg::S_READ;
          end
        end
        dsc_pkg::S_READ: begin
          state_r <= dsc_pkg::S_DONE;
        end
        dsc_pkg::S_DONE: begin
          if (slot_free) begin
            total_r     <= total_nxt;
            rem_run_r   <= rem_final;
            out_valid_r <= 1'b1;
            out_data_r  <= {total_nxt, dsc_pkg::PREFIX_W'(rem_final)};
            pending_r   <= 1'b0;
            state_r     <= dsc_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= dsc_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != dsc_pkg::S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  // a new result only comes out of the update state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == dsc_pkg::S_DONE))
    else $error("result raised outside update state");

  // histogram written only by the sweep or the update
  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == dsc_pkg::S_CLEAR || state_r == dsc_pkg::S_DONE))
    else $error("histogram written in wrong state");

  // final remainder is reduced below the modulus
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsc_pkg::S_DONE) |-> (rem_r < m_eff))
    else $error("remainder not below modulus");
`endif

endmodule
